FILE: rtl/core/tbfm_pkg.sv
package tbfm_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] RegLowGain  = 2'd0;
  localparam logic [1:0] RegMidGain  = 2'd1;
  localparam logic [1:0] RegHighGain = 2'd2;

  localparam int unsigned GainBits  = 16;
  localparam int unsigned GuardBits = 4;
  localparam int unsigned GainFrac  = 12;
  localparam int unsigned TableTaps = 51;
  localparam int unsigned HalfTaps  = 26;
  localparam logic signed [GainBits-1:0] GainReset = 16'sd4096;

  typedef enum logic [1:0] {
    BandLow  = 2'd0,
    BandMid  = 2'd1,
    BandHigh = 2'd2
  } band_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       shift;     // push new sample into the delay line
    logic       clear;     // clear the three accumulators and the mix sum
    logic       mac;       // accumulate one tap
    logic [7:0] tap;       // tap index for mac
    logic       gain;      // apply one band gain to the mix sum
    band_e      band;      // band for gain
    logic       load_out;  // round, saturate, load output register
  } tbfm_cmd_t;

  // Q1.15 half tables, index 0..25
  function automatic logic signed [15:0] lp_half(input logic [4:0] i);
    logic signed [15:0] r;
    unique case (i)
      5'd0: r = -16'sd32;   5'd1: r = -16'sd27;   5'd2: r = -16'sd17;
      5'd3: r = 16'sd1;     5'd4: r = 16'sd30;    5'd5: r = 16'sd67;
      5'd6: r = 16'sd108;   5'd7: r = 16'sd141;   5'd8: r = 16'sd150;
      5'd9: r = 16'sd118;   5'd10: r = 16'sd35;   5'd11: r = -16'sd100;
      5'd12: r = -16'sd273; 5'd13: r = -16'sd452; 5'd14: r = -16'sd594;
      5'd15: r = -16'sd645; 5'd16: r = -16'sd553; 5'd17: r = -16'sd281;
      5'd18: r = 16'sd185;  5'd19: r = 16'sd831;  5'd20: r = 16'sd1607;
      5'd21: r = 16'sd2437; 5'd22: r = 16'sd3227; 5'd23: r = 16'sd3880;
      5'd24: r = 16'sd4310; 5'd25: r = 16'sd4460;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] bp_half(input logic [4:0] i);
    logic signed [15:0] r;
    unique case (i)
      5'd0: r = 16'sd3;     5'd1: r = 16'sd40;    5'd2: r = 16'sd59;
      5'd3: r = -16'sd5;    5'd4: r = -16'sd98;   5'd5: r = -16'sd87;
      5'd6: r = -16'sd4;    5'd7: r = -16'sd71;   5'd8: r = -16'sd293;
      5'd9: r = -16'sd281;  5'd10: r = 16'sd126;  5'd11: r = 16'sd402;
      5'd12: r = 16'sd141;  5'd13: r = -16'sd34;  5'd14: r = 16'sd617;
      5'd15: r = 16'sd1355; 5'd16: r = 16'sd771;  5'd17: r = -16'sd664;
      5'd18: r = -16'sd835; 5'd19: r = 16'sd340;  5'd20: r = -16'sd189;
      5'd21: r = -16'sd3802; 5'd22: r = -16'sd6290; 5'd23: r = -16'sd2405;
      5'd24: r = 16'sd5991; 5'd25: r = 16'sd10432;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] hp_half(input logic [4:0] i);
    logic signed [15:0] r;
    unique case (i)
      5'd0: r = 16'sd29;    5'd1: r = -16'sd13;   5'd2: r = -16'sd42;
      5'd3: r = 16'sd4;     5'd4: r = 16'sd68;    5'd5: r = 16'sd19;
      5'd6: r = -16'sd105;  5'd7: r = -16'sd70;   5'd8: r = 16'sd143;
      5'd9: r = 16'sd162;   5'd10: r = -16'sd161; 5'd11: r = -16'sd301;
      5'd12: r = 16'sd132;  5'd13: r = 16'sd487;  5'd14: r = -16'sd21;
      5'd15: r = -16'sd708; 5'd16: r = -16'sd217; 5'd17: r = 16'sd945;
      5'd18: r = 16'sd648;  5'd19: r = -16'sd1171; 5'd20: r = -16'sd1419;
      5'd21: r = 16'sd1358; 5'd22: r = 16'sd3051; 5'd23: r = -16'sd1482;
      5'd24: r = -16'sd10295; 5'd25: r = 16'sd17930;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Fold a tap index onto the half table; the result is meaningful only for indexes within the table
  function automatic logic [4:0] fold_tap(input logic [7:0] i);
    logic [7:0] f;
    f = (i < 8'(HalfTaps)) ? i : 8'(TableTaps - 1) - i;
    return f[4:0];
  endfunction

endpackage

FILE: rtl/core/tbfm_stream_if.sv
interface tbfm_stream_if #(
  parameter int unsigned Width = 16
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/tbfm_cfg_if.sv
interface tbfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/tbfm_ctrl.sv
module tbfm_ctrl
  import tbfm_pkg::*;
#(
  parameter int unsigned Taps = 51
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_busy_i,  // output register still holds an untaken result
  output tbfm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StMac, StFlush, StGain, StOut
  } state_e;

  state_e     state_q;
  logic [7:0] tap_q;
  logic [1:0] band_q;

  assign in_ready_o = (state_q == StIdle);

  // Commands decoded from state
  always_comb begin
    cmd_o          = '0;
    cmd_o.shift    = (state_q == StIdle) && in_valid_i;
    cmd_o.clear    = cmd_o.shift;
    cmd_o.mac      = (state_q == StMac);
    cmd_o.tap      = tap_q;
    cmd_o.gain     = (state_q == StGain);
    cmd_o.band     = band_e'(band_q);
    cmd_o.load_out = (state_q == StOut) && !out_busy_i;
  end

  // Sequencer: Taps MAC steps, one step for the last registered read,
  // three gain steps, one output step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tap_q   <= '0;
      band_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          tap_q <= '0;
          if (in_valid_i) state_q <= StMac;
        end
        StMac: begin
          tap_q <= tap_q + 8'd1;
          if (tap_q == 8'(Taps - 1)) state_q <= StFlush;
        end
        StFlush: begin
          state_q <= StGain;
          band_q  <= '0;
        end
        StGain: begin
          band_q <= band_q + 2'd1;
          if (band_q == 2'd2) state_q <= StOut;
        end
        StOut: begin
          if (!out_busy_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: rtl/core/tbfm_datapath.sv
module tbfm_datapath
  import tbfm_pkg::*;
#(
  parameter int unsigned Taps       = 51,
  parameter int unsigned SampleBits = 16,
  parameter int unsigned CoefBits   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tbfm_cmd_t                    cmd_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic signed [GainBits-1:0]   gain_low_i,
  input  logic signed [GainBits-1:0]   gain_mid_i,
  input  logic signed [GainBits-1:0]   gain_high_i,
  output logic signed [SampleBits-1:0] result_o
);

  localparam int unsigned ProdBits = SampleBits + CoefBits;
  localparam int unsigned AccBits  = ProdBits + 8;
  localparam int unsigned Shift1   = CoefBits - 1 - GuardBits;
  localparam int unsigned BandBits = AccBits - Shift1 + 1;
  localparam int unsigned MixBits  = BandBits + GainBits + 3;
  localparam int unsigned Shift2   = GuardBits + GainFrac;
  localparam int unsigned AddrBits = $clog2(Taps);

  logic signed [SampleBits-1:0] line_mem [Taps];
  logic signed [AccBits-1:0]    acc_q [3];
  logic signed [MixBits-1:0]    mix_q;

  // Circular delay line state; the fill count makes unwritten slots read as zero
  logic [AddrBits-1:0]          head_q, head_d;
  logic [7:0]                   fill_q;
  logic [AddrBits-1:0]          rd_addr;
  logic [8:0]                   rd_dif, rd_wrap;
  logic signed [SampleBits-1:0] rd_q;
  logic                         rd_zero_q;
  logic                         mac_q;
  logic [7:0]                   mtap_q;

  // Coefficient rescale from Q1.15
  function automatic logic signed [CoefBits-1:0] scale_coef(input logic signed [15:0] q);
    logic signed [40:0] w;
    w = 41'(q) <<< 24;
    w = w + (41'sd1 <<< (24 + 15 - CoefBits));
    return CoefBits >= 16 ? CoefBits'(41'(q) <<< (CoefBits - 16))
                          : CoefBits'(w >>> (24 + 16 - CoefBits));
  endfunction

  logic signed [CoefBits-1:0] c_lp, c_bp, c_hp;
  logic signed [SampleBits-1:0] tap_x;
  logic in_table;

  // Write slot and read slot (newest sample minus tap age)
  always_comb begin
    head_d  = (head_q == AddrBits'(Taps - 1)) ? '0 : head_q + AddrBits'(1);
    rd_dif  = 9'(head_q) - 9'(cmd_i.tap);
    rd_wrap = rd_dif + 9'(Taps);
    rd_addr = (9'(head_q) >= 9'(cmd_i.tap)) ? rd_dif[AddrBits-1:0]
                                            : rd_wrap[AddrBits-1:0];
  end

  // Coefficients come from the registered tap index, in step with the registered read
  always_comb begin
    in_table = mtap_q < 8'(TableTaps);
    c_lp = in_table ? scale_coef(lp_half(fold_tap(mtap_q))) : '0;
    c_bp = in_table ? scale_coef(bp_half(fold_tap(mtap_q))) : '0;
    c_hp = in_table ? scale_coef(hp_half(fold_tap(mtap_q))) : '0;
    tap_x = rd_zero_q ? '0 : rd_q;
  end

  // Band round: floor((acc + half) >> Shift1)
  logic signed [BandBits-1:0] band_val;
  logic signed [GainBits-1:0] gain_sel;
  logic signed [AccBits-1:0]  acc_sel;
  always_comb begin
    unique case (cmd_i.band)
      BandLow:  begin acc_sel = acc_q[0]; gain_sel = gain_low_i;  end
      BandMid:  begin acc_sel = acc_q[1]; gain_sel = gain_mid_i;  end
      BandHigh: begin acc_sel = acc_q[2]; gain_sel = gain_high_i; end
      default:  begin acc_sel = '0;       gain_sel = '0;          end
    endcase
    band_val = BandBits'((AccBits + 1)'(acc_sel)
               + ((AccBits + 1)'(1) <<< (Shift1 - 1)) >>> Shift1);
  end

  // Output round and saturate
  logic signed [MixBits-1:0] mix_r;
  localparam logic signed [MixBits-1:0] Hi = MixBits'((64'sd1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [MixBits-1:0] Lo = -Hi - MixBits'(1);
  always_comb begin
    mix_r = (mix_q + (MixBits'(1) <<< (Shift2 - 1))) >>> Shift2;
  end

  // Write pointer, fill count and read pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= AddrBits'(Taps - 1);
      fill_q    <= '0;
      mac_q     <= 1'b0;
      mtap_q    <= '0;
      rd_zero_q <= 1'b1;
    end else begin
      mac_q  <= cmd_i.mac;
      mtap_q <= cmd_i.tap;
      if (cmd_i.shift) begin
        head_q <= head_d;
        if (fill_q != 8'(Taps)) fill_q <= fill_q + 8'd1;
      end
      if (cmd_i.mac) rd_zero_q <= !(cmd_i.tap < fill_q);
    end
  end

  // Delay line memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) line_mem[head_d] <= sample_i;
    if (cmd_i.mac)   rd_q <= line_mem[rd_addr];
  end

  // Accumulators, mix and output
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      mix_q    <= '0;
    end else if (mac_q) begin
      acc_q[0] <= acc_q[0] + AccBits'(tap_x * c_lp);
      acc_q[1] <= acc_q[1] + AccBits'(tap_x * c_bp);
      acc_q[2] <= acc_q[2] + AccBits'(tap_x * c_hp);
    end else if (cmd_i.gain) begin
      mix_q <= mix_q + MixBits'(band_val * gain_sel);
    end
    if (cmd_i.load_out) begin
      if (mix_r > Hi)      result_o <= Hi[SampleBits-1:0];
      else if (mix_r < Lo) result_o <= Lo[SampleBits-1:0];
      else                 result_o <= mix_r[SampleBits-1:0];
    end
  end

endmodule

FILE: rtl/core/three_band_fir_mixer.sv
// Channel   Dir  Payload                  Transfer
// in_ch     in   audio_in  (SampleBits)   valid & ready
// out_ch    out  mixed_out (SampleBits)   valid & ready
// cfg_ch    in   index, 16-bit gain       valid & ready
// Each sample runs through these steps: one MAC step per tap for all three
// bands, one step for the registered delay-line read, three gain
// steps through one multiplier, one output step.
// A new sample is taken while the previous result waits in the output register.
// Reset empties the delay line (a fill count reads unwritten slots as zero)
// and sets all gains to 1.0; config is always ready.
module three_band_fir_mixer
  import tbfm_pkg::*;
#(
  parameter int unsigned Taps       = 51,
  parameter int unsigned SampleBits = 16,
  parameter int unsigned CoefBits   = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  tbfm_stream_if.sink       in_ch,
  tbfm_stream_if.source     out_ch,
  tbfm_cfg_if.sink          cfg_ch
);

  logic signed [GainBits-1:0] gain_q [3];
  tbfm_cmd_t cmd;
  logic      out_valid_q;
  logic signed [SampleBits-1:0] result;

  assign cfg_ch.ready = 1'b1;

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= GainReset;
      gain_q[1] <= GainReset;
      gain_q[2] <= GainReset;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == RegLowGain)  gain_q[0] <= cfg_ch.wdata;
      if (cfg_ch.index == RegMidGain)  gain_q[1] <= cfg_ch.wdata;
      if (cfg_ch.index == RegHighGain) gain_q[2] <= cfg_ch.wdata;
    end
  end

  tbfm_ctrl #(.Taps(Taps)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_busy_i (out_valid_q && !out_ch.ready),
    .cmd_o      (cmd)
  );

  tbfm_datapath #(.Taps(Taps), .SampleBits(SampleBits), .CoefBits(CoefBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .sample_i    (in_ch.data),
    .gain_low_i  (gain_q[0]),
    .gain_mid_i  (gain_q[1]),
    .gain_high_i (gain_q[2]),
    .result_o    (result)
  );

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = result;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_q && !out_ch.ready))
    else $error("result overwritten");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.shift, cmd.mac, cmd.gain}))
    else $error("overlapping commands");
  a_shift_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> in_ch.ready)
    else $error("shift without transfer");
`endif

endmodule
